// ===== hw/rtl/u2u8_pkg.sv =====
// Shared types and constants for the UTF-16 to UTF-8 encoder.
// No dependencies; every module of the block imports this package.
package u2u8_pkg;

  localparam int unsigned UNIT_W = 16;
  localparam int unsigned POS_W  = 16;

  localparam logic [POS_W-1:0] CAPACITY_RESET = 16'd8192;
  localparam logic [POS_W-1:0] START_RESET    = 16'd0;
  localparam logic [POS_W-1:0] POS_MAX        = 16'hFFFF;

  localparam logic [7:0] QMARK     = 8'h3F;
  localparam logic [7:0] LEAD2     = 8'hC0;
  localparam logic [7:0] LEAD3     = 8'hE0;
  localparam logic [7:0] LEAD4     = 8'hF0;
  localparam logic [7:0] CONT      = 8'h80;
  localparam logic [5:0] HIGH_SURR = 6'b110110;
  localparam logic [5:0] LOW_SURR  = 6'b110111;
  localparam logic [20:0] PLANE1   = 21'h10000;

  typedef enum logic [0:0] {
    REG_OUT_CAPACITY   = 1'b0,
    REG_START_POSITION = 1'b1
  } cfg_index_t;

  // One queue entry: the bytes of one input item, first byte in slot 0.
  // A count of zero is an end-only marker.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    logic            last;
    logic            stopped;
  } entry_t;

endpackage

// ===== hw/rtl/u2u8_if.sv =====
// Valid/ready channel interfaces for the encoder's input and result sides.
// Depends on nothing; used by the front, back and top level.
interface u2u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, code_unit, last_unit, input ready);
  modport sink   (input valid, code_unit, last_unit, output ready);
endinterface

interface u2u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       message_end;
  logic       truncated;

  modport source (output valid, out_byte, byte_valid, run_last, message_end, truncated,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, run_last, message_end, truncated,
                  output ready);
endinterface

// ===== hw/rtl/u2u8_front.sv =====
// Front end: accepts code units, tracks message state and builds queue entries.
// Depends on u2u8_pkg and u2u8_in_if.
module u2u8_front (
  input  logic                clk,
  input  logic                rst_n,
  u2u8_in_if.sink             in_chan,
  input  logic [15:0]         cfg_capacity,
  input  logic [15:0]         cfg_start,
  input  logic                q_full,
  output logic                q_push,
  output u2u8_pkg::entry_t    q_entry
);
  import u2u8_pkg::*;

  logic [15:0] pos_r, pos_nxt;
  logic [9:0]  held_r;
  logic        held_valid_r, held_valid_nxt;
  logic        stopped_r, stopped_nxt;
  logic        mid_r;

  logic        accept;
  logic [15:0] unit, p0, p1;
  logic        last, s0, s1, hv0;
  logic        is_high, is_low;
  logic [20:0] pair_cp;
  logic        ok1, step2, check2, emit2, ok2;
  logic [2:0]  n1, n2, c1, c2;
  logic [16:0] sum1, sum2;
  logic [2:0][7:0] b2;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    unit    = in_chan.code_unit;
    last    = in_chan.last_unit;
    // A new message starts from the configured position with clean flags.
    p0      = mid_r ? pos_r : cfg_start;
    s0      = mid_r ? stopped_r : 1'b0;
    hv0     = mid_r && held_valid_r;
    is_high = (unit[15:10] == HIGH_SURR);
    is_low  = (unit[15:10] == LOW_SURR);
    pair_cp = PLANE1 + {1'b0, held_r, unit[9:0]};

    // Held high surrogate: completes a pair or is written as '?', unless writing has stopped or capacity is reached.
    ok1  = hv0 && !s0 && (p0 < cfg_capacity);
    n1   = is_low ? 3'd4 : 3'd1;
    sum1 = {1'b0, p0} + {14'b0, n1};
    p1   = ok1 ? (sum1[16] ? POS_MAX : sum1[15:0]) : p0;
    s1   = s0 || (hv0 && !ok1);
    c1   = ok1 ? n1 : 3'd0;

    // The unit itself, unless it was consumed as the second half of a pair.
    step2 = !(hv0 && is_low);
    emit2 = 1'b1;
    n2    = 3'd1;
    b2    = '0;
    if (is_high) begin
      emit2 = last;
      b2[0] = QMARK;
    end else if (is_low) begin
      b2[0] = QMARK;
    end else if (unit[15:7] == 9'd0) begin
      b2[0] = (unit[6:0] == 7'd0) ? QMARK : unit[7:0];
    end else if (unit[15:11] == 5'd0) begin
      n2    = 3'd2;
      b2[0] = LEAD2 | {3'b000, unit[10:6]};
      b2[1] = CONT | {2'b00, unit[5:0]};
    end else begin
      n2    = 3'd3;
      b2[0] = LEAD3 | {4'b0000, unit[15:12]};
      b2[1] = CONT | {2'b00, unit[11:6]};
      b2[2] = CONT | {2'b00, unit[5:0]};
    end

    check2         = step2 && !s1 && (p1 < cfg_capacity);
    ok2            = check2 && emit2;
    held_valid_nxt = check2 && is_high && !last;
    stopped_nxt    = s1 || (step2 && !check2);
    sum2           = {1'b0, p1} + {14'b0, n2};
    pos_nxt        = ok2 ? (sum2[16] ? POS_MAX : sum2[15:0]) : p1;
    c2             = ok2 ? n2 : 3'd0;

    if (c1 == 3'd4) begin
      q_entry.bytes[0] = LEAD4 | {5'b00000, pair_cp[20:18]};
      q_entry.bytes[1] = CONT | {2'b00, pair_cp[17:12]};
      q_entry.bytes[2] = CONT | {2'b00, pair_cp[11:6]};
      q_entry.bytes[3] = CONT | {2'b00, pair_cp[5:0]};
    end else if (c1 == 3'd1) begin
      q_entry.bytes[0] = QMARK;
      q_entry.bytes[1] = b2[0];
      q_entry.bytes[2] = b2[1];
      q_entry.bytes[3] = b2[2];
    end else begin
      q_entry.bytes[0] = b2[0];
      q_entry.bytes[1] = b2[1];
      q_entry.bytes[2] = b2[2];
      q_entry.bytes[3] = 8'h00;
    end
    q_entry.count   = c1 + c2;
    q_entry.last    = last;
    q_entry.stopped = stopped_nxt;
  end

  // Items that yield nothing and do not end the message leave no entry.
  assign q_push = accept && ((q_entry.count != 3'd0) || last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      held_valid_r <= 1'b0;
      stopped_r    <= 1'b0;
      mid_r        <= 1'b0;
    end else if (accept) begin
      pos_r        <= pos_nxt;
      held_valid_r <= held_valid_nxt;
      stopped_r    <= stopped_nxt;
      mid_r        <= !last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && held_valid_nxt) begin
      held_r <= unit[9:0];
    end
  end

  a_held_in_message: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> mid_r)
    else $error("held surrogate outside a message");

endmodule

// ===== hw/rtl/u2u8_queue.sv =====
// Short entry queue between the front and the back of the encoder.
// Depends on u2u8_pkg for the entry type.
module u2u8_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u2u8_pkg::entry_t push_entry,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output u2u8_pkg::entry_t head_entry
);
  import u2u8_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

  entry_t            slots_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              do_pop;

  assign full       = (fill_r == CNT_W'(DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_entry = slots_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    fill_nxt = fill_r;
    if (push && !do_pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (!push && do_pop) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("entry pushed into a full queue");

endmodule

// ===== hw/rtl/u2u8_back.sv =====
// Back end: walks the head entry into the output register, one byte per cycle unless out_chan stalls.
// Depends on u2u8_pkg and u2u8_out_if.
module u2u8_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  u2u8_pkg::entry_t head_entry,
  output logic             pop,
  u2u8_out_if.source       out_chan
);
  import u2u8_pkg::*;

  logic [1:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       byte_valid_r, run_last_r, message_end_r, truncated_r;
  logic       load, take, fin, marker;

  assign load   = !out_valid_r || out_chan.ready;
  assign take   = load && head_valid;
  assign marker = (head_entry.count == 3'd0);
  assign fin    = marker || ({1'b0, idx_r} == head_entry.count - 3'd1);
  assign pop    = take && fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= head_valid;
      if (take) begin
        idx_r <= fin ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte_r    <= marker ? 8'h00 : head_entry.bytes[idx_r];
      byte_valid_r  <= !marker;
      run_last_r    <= fin;
      message_end_r <= fin && head_entry.last;
      truncated_r   <= head_entry.stopped;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_byte    = out_byte_r;
  assign out_chan.byte_valid  = byte_valid_r;
  assign out_chan.run_last    = run_last_r;
  assign out_chan.message_end = message_end_r;
  assign out_chan.truncated   = truncated_r;

  a_marker_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !byte_valid_r) |-> (run_last_r && message_end_r))
    else $error("end-only marker that does not close its message");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && message_end_r) |-> run_last_r)
    else $error("message end before the last byte of its unit");

  a_index_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 2'd0) |-> head_valid)
    else $error("byte index left part-way with no entry at the head");

endmodule

// ===== hw/rtl/utf16_to_utf8_encoder_core.sv =====
// Top level of the UTF-16 to UTF-8 encoder: configuration registers and wiring.
// Depends on u2u8_pkg, u2u8_if, u2u8_front, u2u8_queue and u2u8_back.
//
// Usage: in_chan carries one UTF-16 code unit per transfer, with last_unit on
// the final unit of a message. out_chan carries one UTF-8 byte per transfer;
// run_last closes the bytes of one unit, message_end closes the message and a
// transfer with byte_valid low is an end-only marker for a unit that gave no
// byte. truncated reports that writing stopped at out_capacity.
// The cfg port writes out_capacity (index 0) or start_position (index 1) at
// any edge with cfg_we high; the user must write only while the block is idle,
// which the block does not enforce. With the queue empty, a unit's first byte
// passes a queue slot and then the output register before it is offered. The
// output register moves one byte per cycle while the receiver is ready; a unit
// yields up to four bytes, a marker, or no entry for a held high surrogate.
// The front end takes a unit every cycle while the entry queue of
// QUEUE_DEPTH entries has room, so short bursts pass at full input rate.
// Reset clears the message state, the queue and the output register and loads
// the register defaults. When the receiver stalls the output holds its byte,
// the queue fills, and in_chan.ready falls once it is full.
module utf16_to_utf8_encoder_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  u2u8_in_if.sink                in_chan,
  u2u8_out_if.source             out_chan,
  input  logic                   cfg_we,
  input  u2u8_pkg::cfg_index_t   cfg_index,
  input  logic [15:0]            cfg_wdata
);
  import u2u8_pkg::*;

  logic [15:0] capacity_r, start_r;
  logic        q_push, q_pop, q_full, q_head_valid;
  entry_t      q_push_entry, q_head_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAPACITY_RESET;
      start_r    <= START_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OUT_CAPACITY:   capacity_r <= cfg_wdata;
        REG_START_POSITION: start_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  u2u8_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .cfg_capacity (capacity_r),
    .cfg_start    (start_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_entry      (q_push_entry)
  );

  u2u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_entry (q_head_entry)
  );

  u2u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_entry (q_head_entry),
    .pop        (q_pop),
    .out_chan   (out_chan)
  );

endmodule
